### rtl/core/cwp_pkg.sv
// shared types, widths and constants of the world point projection block
`timescale 1ns / 1ps
`default_nettype none

package cwp_pkg;

    // field and datapath widths
    localparam int WORLD_W   = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = 32;
    localparam int FRAC      = 12;
    localparam int VIEW_W    = 45;
    localparam int MAG_W     = 44;
    localparam int H_W       = 16;
    localparam int TRANS_W   = 32;
    localparam int NUM_W     = 60;
    localparam int ZD_W      = 28;
    localparam int DPROD_W   = 44;
    localparam int SCALE_SH  = 17;
    localparam int DIV_STEPS = 34;
    localparam int DIV_N_W   = 78;
    localparam int DIV_D_W   = 45;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 32;
    localparam int ORDER_W   = 17;
    localparam int SUM_W     = 36;

    // far depth limit in 12 fraction bits, top near value, 1.0 of the order
    localparam logic [ZD_W-1:0]           FAR_DEPTH = 28'hFFFF000;
    localparam logic [H_W-1:0]            NEAR_TOP  = 16'hFFFF;
    localparam logic [ORDER_W-1:0]        ORDER_ONE = 17'h10000;
    localparam logic signed [OUT_W-1:0]   OUT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0]   OUT_MIN   = 32'sh8000_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0,
        CFG_ROT_ROW1,
        CFG_ROT_ROW2,
        CFG_TRANS_XY,
        CFG_TRANS_Z,
        CFG_OFFSET_XY,
        CFG_PROJ_H,
        CFG_NEAR_DEPTH
    } t_cfg_idx;

    // how the depth order is formed
    typedef enum logic [1:0] {
        DM_DIVIDE,
        DM_ZERO,
        DM_ONE
    } t_dmode;

    // camera set-up seen by the datapath
    typedef struct packed {
        logic [2:0][2:0][COEF_W-1:0] rot;
        logic signed [TRANS_W-1:0]   tx;
        logic signed [TRANS_W-1:0]   ty;
        logic signed [TRANS_W-1:0]   tz;
        logic [H_W-1:0]              h;
        logic [H_W-1:0]              near;
    } t_cam;

    // view coordinates with 12 fraction bits
    typedef struct packed {
        logic signed [VIEW_W-1:0] vx;
        logic signed [VIEW_W-1:0] vy;
        logic signed [VIEW_W-1:0] vz;
    } t_view;

    // per item flags that ride alongside the dividers
    typedef struct packed {
        logic   neg_x;
        logic   neg_y;
        logic   on;
        t_dmode mode;
    } t_side;

    // divider operands and result
    typedef struct packed {
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic [DIV_STEPS-1:0] quo;
        logic                 sat;
    } t_div_out;

endpackage

`default_nettype wire

### rtl/core/cwp_xform.sv
// rotation and translation stages: world point to view coordinates
`timescale 1ns / 1ps
`default_nettype none

module cwp_xform (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire signed [cwp_pkg::WORLD_W-1:0]    i_world_x,
    input  wire signed [cwp_pkg::WORLD_W-1:0]    i_world_y,
    input  wire signed [cwp_pkg::WORLD_W-1:0]    i_world_z,
    input  wire cwp_pkg::t_cam                   i_cam,
    output logic                                 o_valid,
    output cwp_pkg::t_view                       o_view
);
    import cwp_pkg::*;

    logic signed [WORLD_W-1:0] w [3];
    logic signed [PROD_W-1:0]  r_prod [3][3];
    logic                      r_prod_v;
    logic signed [TRANS_W-1:0] trans [3];
    logic signed [VIEW_W-1:0]  n_sum [3];
    t_view                     r_view;
    logic                      r_view_v;

    assign w[0] = i_world_x;
    assign w[1] = i_world_y;
    assign w[2] = i_world_z;

    assign trans[0] = i_cam.tx;
    assign trans[1] = i_cam.ty;
    assign trans[2] = i_cam.tz;

    // nine coefficient products
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[r][j] <= signed'(i_cam.rot[r][j]) * w[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_valid;
        end
    end

    // row sums plus translation scaled to 12 fraction bits
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = VIEW_W'(r_prod[r][0]) + VIEW_W'(r_prod[r][1])
                     + VIEW_W'(r_prod[r][2])
                     + VIEW_W'(signed'({trans[r], {FRAC{1'b0}}}));
        end
    end

    always_ff @(posedge i_clk) begin
        r_view.vx <= n_sum[0];
        r_view.vy <= n_sum[1];
        r_view.vz <= n_sum[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_v <= 1'b0;
        end else begin
            r_view_v <= r_prod_v;
        end
    end

    assign o_valid = r_view_v;
    assign o_view  = r_view;

endmodule

`default_nettype wire

### rtl/core/cwp_prep.sv
// projection set-up: depth clamps, magnitudes, products and divider operands
`timescale 1ns / 1ps
`default_nettype none

module cwp_prep (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire cwp_pkg::t_view      i_view,
    input  wire cwp_pkg::t_cam       i_cam,
    output logic                     o_valid,
    output cwp_pkg::t_div_in         o_div_x,
    output cwp_pkg::t_div_in         o_div_y,
    output cwp_pkg::t_div_in         o_div_z,
    output cwp_pkg::t_side           o_side
);
    import cwp_pkg::*;

    logic [H_W-1:0]   nr;
    logic [MAG_W-1:0] hz;
    logic [MAG_W-1:0] pz;
    logic [ZD_W-1:0]  zc;
    logic             z_big;
    logic [MAG_W-1:0] z_mag;
    t_side            n_side;

    logic             r_c_v;
    logic [MAG_W-1:0] r_ax, r_ay, r_pz;
    logic [H_W-1:0]   r_h, r_nr, r_nrm;
    logic [ZD_W-1:0]  r_fm, r_zf;
    t_side            r_side_c;

    logic               r_d_v;
    logic [NUM_W-1:0]   r_numx, r_numy;
    logic [DPROD_W-1:0] r_dn, r_dd;
    logic [MAG_W-1:0]   r_pz_d;
    t_side              r_side_d;

    logic    r_e_v;
    t_div_in r_div_x, r_div_y, r_div_z;
    t_side   r_side_e;

    // clamps and depth order special cases
    always_comb begin
        nr     = (i_cam.near == '0) ? H_W'(1) : i_cam.near;
        hz     = MAG_W'({i_cam.h, {(FRAC-1){1'b0}}});
        pz     = (i_view.vz > $signed({1'b0, hz})) ? MAG_W'(i_view.vz) : hz;
        zc     = {nr, {FRAC{1'b0}}};
        z_big  = i_view.vz > $signed({{(VIEW_W-ZD_W){1'b0}}, zc});
        z_mag  = z_big ? MAG_W'(i_view.vz) : MAG_W'(zc);
        n_side.neg_x = i_view.vx < 0;
        n_side.neg_y = i_view.vy < 0;
        n_side.on    = (i_cam.h != '0) && (i_view.vz > 0);
        priority if (nr == NEAR_TOP) begin
            n_side.mode = (z_mag == MAG_W'(FAR_DEPTH)) ? DM_ONE : DM_ZERO;
        end else if (z_mag >= MAG_W'(FAR_DEPTH)) begin
            n_side.mode = DM_ZERO;
        end else begin
            n_side.mode = DM_DIVIDE;
        end
    end

    // stage c: magnitudes and clamped depths
    always_ff @(posedge i_clk) begin
        r_ax     <= MAG_W'(n_side.neg_x ? -i_view.vx : i_view.vx);
        r_ay     <= MAG_W'(n_side.neg_y ? -i_view.vy : i_view.vy);
        r_pz     <= pz;
        r_h      <= i_cam.h;
        r_nr     <= nr;
        r_nrm    <= NEAR_TOP - nr;
        r_zf     <= z_mag[ZD_W-1:0];
        r_fm     <= FAR_DEPTH - z_mag[ZD_W-1:0];
        r_side_c <= n_side;
    end

    // stage d: products
    always_ff @(posedge i_clk) begin
        r_numx   <= r_ax * r_h;
        r_numy   <= r_ay * r_h;
        r_dn     <= r_nr * r_fm;
        r_dd     <= r_zf * r_nrm;
        r_pz_d   <= r_pz;
        r_side_d <= r_side_c;
    end

    // stage e: rounding numerators and doubled divisors
    always_ff @(posedge i_clk) begin
        r_div_x.num <= DIV_N_W'({r_numx, {SCALE_SH{1'b0}}}) + DIV_N_W'(r_pz_d);
        r_div_x.den <= {r_pz_d, 1'b0};
        r_div_y.num <= DIV_N_W'({r_numy, {SCALE_SH{1'b0}}}) + DIV_N_W'(r_pz_d);
        r_div_y.den <= {r_pz_d, 1'b0};
        r_div_z.num <= DIV_N_W'({r_dn, {SCALE_SH{1'b0}}}) + DIV_N_W'(r_dd);
        r_div_z.den <= DIV_D_W'({r_dd, 1'b0});
        r_side_e    <= r_side_d;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            r_c_v <= i_valid;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    assign o_valid = r_e_v;
    assign o_div_x = r_div_x;
    assign o_div_y = r_div_y;
    assign o_div_z = r_div_z;
    assign o_side  = r_side_e;

endmodule

`default_nettype wire

### rtl/core/cwp_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
`timescale 1ns / 1ps
`default_nettype none

module cwp_div (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire cwp_pkg::t_div_in i_div,
    output logic                  o_valid,
    output cwp_pkg::t_div_out     o_res
);
    import cwp_pkg::*;

    logic                 r_v   [DIV_STEPS+1];
    logic                 r_sat [DIV_STEPS+1];
    logic [DIV_D_W-1:0]   r_rem [DIV_STEPS+1];
    logic [DIV_D_W-1:0]   r_den [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_low [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS+1];

    // entry: quotient too wide for the stages saturates
    always_ff @(posedge i_clk) begin
        r_rem[0] <= DIV_D_W'(i_div.num[DIV_N_W-1:DIV_STEPS]);
        r_sat[0] <= DIV_D_W'(i_div.num[DIV_N_W-1:DIV_STEPS]) >= i_div.den;
        r_den[0] <= i_div.den;
        r_low[0] <= i_div.num[DIV_STEPS-1:0];
        r_quo[0] <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    // one trial subtraction per stage
    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        logic [DIV_D_W:0] trial;
        logic             take;

        assign trial = {r_rem[s-1], r_low[s-1][DIV_STEPS-1]};
        assign take  = trial >= {1'b0, r_den[s-1]};

        always_ff @(posedge i_clk) begin
            r_rem[s] <= take ? DIV_D_W'(trial - {1'b0, r_den[s-1]}) : DIV_D_W'(trial);
            r_low[s] <= r_low[s-1] << 1;
            r_quo[s] <= {r_quo[s-1][DIV_STEPS-2:0], take};
            r_den[s] <= r_den[s-1];
            r_sat[s] <= r_sat[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    assign o_valid   = r_v[DIV_STEPS];
    assign o_res.quo = r_quo[DIV_STEPS];
    assign o_res.sat = r_sat[DIV_STEPS];

    // remainder at the last stage is below the divisor unless saturated
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[DIV_STEPS] && !r_sat[DIV_STEPS] |-> r_rem[DIV_STEPS] < r_den[DIV_STEPS])
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### rtl/core/camera_world_point_projection.sv
// top level: configuration registers, datapath pipeline and result stage
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  item in   | start, busy               | i_world_x, i_world_y, i_world_z
//  config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//  result    | o_strobe (one cycle)      | o_screen_x, o_screen_y, o_on_screen,
//            |                           | o_depth_order
//
//  one item can be taken every cycle; busy stays low
//  start to o_strobe passes the transform and set-up registers, the 34 stage quotient
//  pipelines (one bit per stage) with their entry registers, and the output registers
//  synchronous active low reset clears valid bits and loads register defaults
//  the result is shown for one cycle only; the receiver cannot stall it
`timescale 1ns / 1ps
`default_nettype none

module camera_world_point_projection (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire signed [cwp_pkg::WORLD_W-1:0]       i_world_x,
    input  wire signed [cwp_pkg::WORLD_W-1:0]       i_world_y,
    input  wire signed [cwp_pkg::WORLD_W-1:0]       i_world_z,
    input  wire                                     i_cfg_we,
    input  wire [cwp_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  wire [cwp_pkg::CFG_W-1:0]                i_cfg_data,
    output logic                                    o_strobe,
    output logic signed [cwp_pkg::OUT_W-1:0]        o_screen_x,
    output logic signed [cwp_pkg::OUT_W-1:0]        o_screen_y,
    output logic                                    o_on_screen,
    output logic [cwp_pkg::ORDER_W-1:0]             o_depth_order
);
    import cwp_pkg::*;

    t_cam                     r_cam;
    logic signed [OUT_W-1:0]  r_off_x, r_off_y;

    logic     xf_v;
    t_view    xf_view;
    logic     pp_v;
    t_div_in  pp_div_x, pp_div_y, pp_div_z;
    t_side    pp_side;
    logic     dv_x, dv_y, dv_z;
    t_div_out dr_x, dr_y, dr_z;
    t_side    r_side [DIV_STEPS+1];
    t_side    side;
    logic     res_v;

    logic signed [OUT_W-1:0]   n_sx, n_sy;
    logic [ORDER_W-1:0]        n_order;

    logic                      r_strobe;
    logic                      r_on;
    logic signed [OUT_W-1:0]   r_sx, r_sy;
    logic [ORDER_W-1:0]        r_order;

    // offset plus signed quotient, clipped to 32 bits
    function automatic logic signed [OUT_W-1:0] proj_clip(
        input logic signed [OUT_W-1:0] off,
        input logic                    neg,
        input t_div_out                q
    );
        logic signed [SUM_W-1:0] mag;
        logic signed [SUM_W-1:0] sum;
        mag = signed'(SUM_W'(q.quo));
        sum = SUM_W'(off) + (neg ? -mag : mag);
        priority if (q.sat) begin
            proj_clip = neg ? OUT_MIN : OUT_MAX;
        end else if (sum > SUM_W'(OUT_MAX)) begin
            proj_clip = OUT_MAX;
        end else if (sum < SUM_W'(OUT_MIN)) begin
            proj_clip = OUT_MIN;
        end else begin
            proj_clip = OUT_W'(sum);
        end
    endfunction

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam      <= '0;
            r_cam.near <= H_W'(1);
            r_off_x    <= '0;
            r_off_y    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_ROW0:   r_cam.rot[0] <= i_cfg_data[3*COEF_W-1:0];
                CFG_ROT_ROW1:   r_cam.rot[1] <= i_cfg_data[3*COEF_W-1:0];
                CFG_ROT_ROW2:   r_cam.rot[2] <= i_cfg_data[3*COEF_W-1:0];
                CFG_TRANS_XY: begin
                    r_cam.tx <= i_cfg_data[TRANS_W-1:0];
                    r_cam.ty <= i_cfg_data[2*TRANS_W-1:TRANS_W];
                end
                CFG_TRANS_Z:    r_cam.tz <= i_cfg_data[TRANS_W-1:0];
                CFG_OFFSET_XY: begin
                    r_off_x <= i_cfg_data[OUT_W-1:0];
                    r_off_y <= i_cfg_data[2*OUT_W-1:OUT_W];
                end
                CFG_PROJ_H:     r_cam.h <= i_cfg_data[H_W-1:0];
                CFG_NEAR_DEPTH: r_cam.near <= i_cfg_data[H_W-1:0];
                default: ;
            endcase
        end
    end

    // view transform
    cwp_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start & ~busy),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .i_cam     (r_cam),
        .o_valid   (xf_v),
        .o_view    (xf_view)
    );

    // projection set-up
    cwp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xf_v),
        .i_view  (xf_view),
        .i_cam   (r_cam),
        .o_valid (pp_v),
        .o_div_x (pp_div_x),
        .o_div_y (pp_div_y),
        .o_div_z (pp_div_z),
        .o_side  (pp_side)
    );

    // three quotient pipelines
    cwp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pp_v),
        .i_div   (pp_div_x),
        .o_valid (dv_x),
        .o_res   (dr_x)
    );

    cwp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pp_v),
        .i_div   (pp_div_y),
        .o_valid (dv_y),
        .o_res   (dr_y)
    );

    cwp_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pp_v),
        .i_div   (pp_div_z),
        .o_valid (dv_z),
        .o_res   (dr_z)
    );

    // flags delayed to meet the quotients
    always_ff @(posedge i_clk) begin
        r_side[0] <= pp_side;
        for (int i = 1; i <= DIV_STEPS; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    assign side  = r_side[DIV_STEPS];
    assign res_v = dv_x & dv_y & dv_z;

    // result formatting
    always_comb begin
        n_sx = '0;
        n_sy = '0;
        if (side.on) begin
            n_sx = proj_clip(r_off_x, side.neg_x, dr_x);
            n_sy = proj_clip(r_off_y, side.neg_y, dr_y);
        end
        unique case (side.mode)
            DM_ZERO:   n_order = '0;
            DM_ONE:    n_order = ORDER_ONE;
            DM_DIVIDE: begin
                n_order = (dr_z.sat || dr_z.quo > DIV_STEPS'(ORDER_ONE))
                        ? ORDER_ONE : dr_z.quo[ORDER_W-1:0];
            end
            default:   n_order = '0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_order <= n_order;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_on     <= 1'b0;
        end else begin
            r_strobe <= res_v;
            r_on     <= res_v & side.on;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_on_screen   = r_on;
    assign o_screen_x    = r_sx;
    assign o_screen_y    = r_sy;
    assign o_depth_order = r_order;

    // on screen flag only with a result
    a_on_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_on_screen |-> o_strobe)
        else $error("on screen flag without result strobe");

    // off screen results carry zero coordinates
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_on_screen |-> o_screen_x == '0 && o_screen_y == '0)
        else $error("off screen item with non-zero coordinates");

    // depth order never above one
    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_depth_order <= ORDER_ONE)
        else $error("depth order above one");

endmodule

`default_nettype wire
